FILE: sv/i32alu_pkg.sv
package i32alu_pkg;

	localparam int unsigned WordW = 32;

	// Operation codes carried in the operation field.
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_REM = 3'd4;

	typedef struct packed {
		logic [2:0]        operation;
		logic signed [31:0] left_operand;
		logic signed [31:0] right_operand;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               result_valid;
	} out_t;

	// Item as it travels down the divider chain.
	typedef struct packed {
		logic [2:0]  op;
		logic        ok;      // result defined
		logic        neg_quo; // quotient must be negated at the end
		logic        neg_rem; // remainder must be negated at the end
		logic [31:0] early;   // add, subtract or multiply result
		logic [31:0] rem;     // partial remainder magnitude
		logic [31:0] quo;     // dividend bits shift out, quotient bits shift in
		logic [31:0] dvs;     // divisor magnitude
	} cell_t;

endpackage

FILE: sv/int32_alu_with_checked_divide.sv
// Signed 32-bit ALU: add, subtract, multiply, divide and remainder.
// An operation enters on the op channel (op_valid, op_ready, op_data) and its
// result leaves on the res channel (res_valid, res_ready, res_data); each
// channel moves one transfer when valid and ready are both high.
// Every operation, whatever its code, runs the same path: one preparation
// stage (add, subtract, multiply, operand magnitudes), a chain of 32
// division cells that each produce one quotient bit, and one final stage
// that fixes the signs and drives the output register. One operation is
// accepted per cycle unless the receiver stalls a full pipeline.
// A divisor of zero gives result_valid low and result_value zero; the
// minimum value divided by minus one gives the minimum value and remainder 0.
// Reset clears the valid bit of every stage, so the pipeline comes up empty.
// When the receiver stalls, the result holds in the output register and
// each stage still moves forward into an empty stage ahead of it, so gaps
// close up and up to 34 operations are held before op_ready drops.
module int32_alu_with_checked_divide (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  i32alu_pkg::in_t   op_data,
	output logic              res_valid,
	input  logic              res_ready,
	output i32alu_pkg::out_t  res_data
);

	localparam int unsigned NumCells = i32alu_pkg::WordW;

	// Handshake and payload between neighboring stages. Index 0 is the
	// preparation stage output; index k is the output of division cell k-1.
	logic              chain_valid [NumCells+1];
	logic              chain_ready [NumCells+1];
	i32alu_pkg::cell_t chain_data  [NumCells+1];

	i32alu_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (op_valid),
		.up_ready (op_ready),
		.up_data  (op_data),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_data  (chain_data[0])
	);

	// Each cell retires one dividend bit, most significant first.
	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		i32alu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_data  (chain_data[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_data  (chain_data[k+1])
		);
	end

	// Sign correction, result selection and the output register.
	i32alu_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[NumCells]),
		.up_ready (chain_ready[NumCells]),
		.up_data  (chain_data[NumCells]),
		.dn_valid (res_valid),
		.dn_ready (res_ready),
		.dn_data  (res_data)
	);

endmodule

FILE: sv/i32alu_prep.sv
module i32alu_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  i32alu_pkg::in_t    up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output i32alu_pkg::cell_t  dn_data
);

	logic              valid_s1;
	i32alu_pkg::cell_t data_s1;
	i32alu_pkg::cell_t nxt;
	logic [31:0]       a_u;
	logic [31:0]       b_u;
	logic [31:0]       mul_lo;

	assign a_u    = up_data.left_operand;
	assign b_u    = up_data.right_operand;
	assign mul_lo = a_u * b_u;

	always_comb begin
		nxt         = '0;
		nxt.op      = up_data.operation;
		nxt.neg_quo = a_u[31] ^ b_u[31];
		nxt.neg_rem = a_u[31];
		nxt.rem     = '0;
		nxt.quo     = a_u[31] ? (~a_u + 32'd1) : a_u;
		nxt.dvs     = b_u[31] ? (~b_u + 32'd1) : b_u;
		case (up_data.operation)
			i32alu_pkg::OP_ADD: begin
				nxt.early = a_u + b_u;
				nxt.ok    = 1'b1;
			end
			i32alu_pkg::OP_SUB: begin
				nxt.early = a_u - b_u;
				nxt.ok    = 1'b1;
			end
			i32alu_pkg::OP_MUL: begin
				nxt.early = mul_lo;
				nxt.ok    = 1'b1;
			end
			i32alu_pkg::OP_DIV,
			i32alu_pkg::OP_REM: begin
				nxt.ok = (b_u != 32'd0);
			end
			default: begin
				nxt.ok = 1'b0;
			end
		endcase
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

FILE: sv/i32alu_cell.sv
module i32alu_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  i32alu_pkg::cell_t  up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output i32alu_pkg::cell_t  dn_data
);

	logic              valid_q;
	i32alu_pkg::cell_t data_q;
	i32alu_pkg::cell_t nxt;
	logic [31:0]       shifted;
	logic [32:0]       diff;

	// One restoring step: bring down the next dividend bit, try the subtract.
	assign shifted = {up_data.rem[30:0], up_data.quo[31]};
	assign diff    = {1'b0, shifted} - {1'b0, up_data.dvs};

	always_comb begin
		nxt = up_data;
		if (diff[32]) begin
			nxt.rem = shifted;
			nxt.quo = {up_data.quo[30:0], 1'b0};
		end else begin
			nxt.rem = diff[31:0];
			nxt.quo = {up_data.quo[30:0], 1'b1};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

FILE: sv/i32alu_post.sv
module i32alu_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  i32alu_pkg::cell_t  up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output i32alu_pkg::out_t   dn_data
);

	logic             valid_q;
	i32alu_pkg::out_t data_q;
	i32alu_pkg::out_t nxt;
	logic [31:0]      quo_s;
	logic [31:0]      rem_s;
	logic [31:0]      sel;

	assign quo_s = up_data.neg_quo ? (~up_data.quo + 32'd1) : up_data.quo;
	assign rem_s = up_data.neg_rem ? (~up_data.rem + 32'd1) : up_data.rem;

	always_comb begin
		case (up_data.op)
			i32alu_pkg::OP_DIV: sel = quo_s;
			i32alu_pkg::OP_REM: sel = rem_s;
			default:            sel = up_data.early;
		endcase
		nxt.result_valid = up_data.ok;
		nxt.result_value = up_data.ok ? sel : 32'd0;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
